// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, muted while reset is asserted
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/stu_pkg.sv -----
// types, constants and helpers of the string to unsigned parser
// used by stu_char_step, the top level and the checker
package stu_pkg;

  localparam int VALUE_WIDTH  = 32;
  localparam int OFFSET_WIDTH = 16;
  localparam int BASE_W       = 6;
  localparam int CHAR_W       = 8;
  localparam int DIGIT_W      = 7;
  localparam int PROD_W       = VALUE_WIDTH + BASE_W + 1;

  localparam logic [BASE_W-1:0] BASE_MAX   = BASE_W'(36);
  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_AUTO  = BASE_W'(0);
  localparam logic [BASE_W-1:0] BASE_ONE   = BASE_W'(1);
  localparam logic [BASE_W-1:0] BASE_OCT   = BASE_W'(8);
  localparam logic [BASE_W-1:0] BASE_DEC   = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_HEX   = BASE_W'(16);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
  localparam logic [CHAR_W-1:0] ALPHA_OFS = 8'd10;

  localparam logic [DIGIT_W-1:0] DIGIT_NONE = DIGIT_W'(99);
  localparam logic [DIGIT_W-1:0] DIGIT_HEX_LIMIT = DIGIT_W'(16);

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [1:0] STATUS_NO_DIGIT = 2'd2;
  localparam logic [1:0] STATUS_INVALID  = 2'd3;

  typedef enum logic [2:0] {
    PH_SPACE  = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_ZEROX  = 3'd3,
    PH_DIGITS = 3'd4,
    PH_DONE   = 3'd5,
    PH_BAD    = 3'd6
  } phase_e;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0]  parsed_value;
    logic [OFFSET_WIDTH-1:0] end_offset;
    logic [1:0]              status;
  } out_word_t;

  typedef struct packed {
    phase_e                  parse_phase;
    logic [BASE_W-1:0]       active_base;
    logic                    negative_sign;
    logic [VALUE_WIDTH-1:0]  accumulator;
    logic                    overflow_seen;
    logic [OFFSET_WIDTH-1:0] char_position;
    logic [OFFSET_WIDTH-1:0] digits_end;
    logic                    digit_seen;
  } parse_state_t;

  localparam parse_state_t STATE_CLEAR = '{
    parse_phase:   PH_SPACE,
    active_base:   '0,
    negative_sign: 1'b0,
    accumulator:   '0,
    overflow_seen: 1'b0,
    char_position: '0,
    digits_end:    '0,
    digit_seen:    1'b0
  };

  // digit weight of a character in any radix up to 36, DIGIT_NONE otherwise
  function automatic logic [DIGIT_W-1:0] digit_value(logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = CHAR_W'(DIGIT_NONE);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = c - (CH_LO_A - ALPHA_OFS);
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = c - (CH_UP_A - ALPHA_OFS);
    end
    return d[DIGIT_W-1:0];
  endfunction

  // position counter that sticks at all ones
  function automatic logic [OFFSET_WIDTH-1:0] sat_next(logic [OFFSET_WIDTH-1:0] p);
    return (&p) ? p : p + OFFSET_WIDTH'(1);
  endfunction

endpackage

// ----- sv/string_to_unsigned_parser_unit.sv -----
// top level of the string to unsigned parser
// depends on stu_pkg and stu_char_step
//
// usage
//   input channel carries one character word (char_code, last_char) per cycle
//   while in_stall_o is low; the word with last_char set closes the string and
//   yields one result word (parsed_value, end_offset, status) on the output channel
//   config channel writes number_base (0 = auto radix, 2..36); cfg_ready_o is
//   always high, a new base applies from the first character of the next string
// flow
//   a character is accepted every cycle while in_stall_o is low; it is held in
//   the input register, then the step logic (one 32x6 multiply-add plus
//   saturation check) updates the parse state; the result word of the last
//   character is registered in the output register
// reset
//   rst_ni clears both channels, the parse state and sets number_base to 10
// backpressure
//   while out_stall_i holds a result, non-final characters keep flowing; a
//   final character waits in the input register and in_stall_o rises until
//   the output register frees up
module string_to_unsigned_parser_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // character stream
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  stu_pkg::in_word_t             in_data_i,
  // result stream
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output stu_pkg::out_word_t            out_data_o,
  // base register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [stu_pkg::BASE_W-1:0]    cfg_data_i
);

  logic [stu_pkg::BASE_W-1:0] base_q;

  logic                  in_vld_q;
  stu_pkg::in_word_t     in_q;

  stu_pkg::parse_state_t state_q, state_d, step_state;
  stu_pkg::out_word_t    step_result;

  logic                  out_vld_q;
  stu_pkg::out_word_t    out_q;

  logic out_free;
  logic advance;
  logic accept;

  // base register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= stu_pkg::BASE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= cfg_data_i;
    end
  end

  // the step may proceed unless a final character meets a held result
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && (!in_q.last_char || out_free);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  stu_char_step u_step (
    .state_i       (state_q),
    .char_code_i   (in_q.char_code),
    .number_base_i (base_q),
    .state_o       (step_state),
    .result_o      (step_result)
  );

  // parse state: cleared once a string is closed
  always_comb begin
    state_d = state_q;
    if (advance) begin
      state_d = in_q.last_char ? stu_pkg::STATE_CLEAR : step_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stu_pkg::STATE_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && in_q.last_char) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.last_char) begin
      out_q <= step_result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/stu_char_step.sv -----
// next parse state for one character, and the result word it would close with
// depends on stu_pkg
module stu_char_step (
  input  stu_pkg::parse_state_t        state_i,
  input  logic [stu_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [stu_pkg::BASE_W-1:0]   number_base_i,
  output stu_pkg::parse_state_t        state_o,
  output stu_pkg::out_word_t           result_o
);

  stu_pkg::parse_state_t              nxt;
  logic [stu_pkg::DIGIT_W-1:0]        dval;
  logic                               start;
  logic                               take;
  logic [stu_pkg::PROD_W-1:0]         wide;
  logic [stu_pkg::OFFSET_WIDTH-1:0]   pos;

  assign dval = stu_pkg::digit_value(char_code_i);
  assign pos  = state_i.char_position;

  always_comb begin
    nxt   = state_i;
    start = 1'b0;
    take  = 1'b0;
    wide  = '0;

    // first character of a string samples the radix
    if (pos == '0 && state_i.parse_phase == stu_pkg::PH_SPACE) begin
      if (number_base_i == stu_pkg::BASE_ONE || number_base_i > stu_pkg::BASE_MAX ||
          char_code_i == stu_pkg::CH_NUL) begin
        nxt.parse_phase = stu_pkg::PH_BAD;
      end else begin
        nxt.active_base = number_base_i;
      end
    end

    case (nxt.parse_phase)
      stu_pkg::PH_SPACE: begin
        if (char_code_i inside {[stu_pkg::CH_TAB:stu_pkg::CH_CR], stu_pkg::CH_SPACE}) begin
          nxt.parse_phase = stu_pkg::PH_SPACE;
        end else if (char_code_i == stu_pkg::CH_PLUS || char_code_i == stu_pkg::CH_MINUS) begin
          nxt.negative_sign = (char_code_i == stu_pkg::CH_MINUS);
          nxt.parse_phase   = stu_pkg::PH_SIGNED;
        end else begin
          start = 1'b1;
        end
      end
      stu_pkg::PH_SIGNED: begin
        start = 1'b1;
      end
      stu_pkg::PH_ZERO: begin
        if (char_code_i == stu_pkg::CH_LO_X ||
            (nxt.active_base == stu_pkg::BASE_AUTO && char_code_i == stu_pkg::CH_UP_X)) begin
          nxt.parse_phase = stu_pkg::PH_ZEROX;
        end else begin
          if (nxt.active_base == stu_pkg::BASE_AUTO) nxt.active_base = stu_pkg::BASE_OCT;
          take = 1'b1;
        end
      end
      stu_pkg::PH_ZEROX: begin
        if (dval < stu_pkg::DIGIT_HEX_LIMIT) begin
          nxt.active_base = stu_pkg::BASE_HEX;
          take = 1'b1;
        end else begin
          nxt.parse_phase = stu_pkg::PH_DONE;
        end
      end
      stu_pkg::PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        nxt.parse_phase = nxt.parse_phase;
      end
    endcase

    // leading zero may open a radix prefix
    if (start) begin
      if ((nxt.active_base == stu_pkg::BASE_AUTO || nxt.active_base == stu_pkg::BASE_HEX) &&
          char_code_i == stu_pkg::CH_ZERO) begin
        nxt.digit_seen  = 1'b1;
        nxt.accumulator = '0;
        nxt.digits_end  = stu_pkg::sat_next(pos);
        nxt.parse_phase = stu_pkg::PH_ZERO;
      end else begin
        if (nxt.active_base == stu_pkg::BASE_AUTO) nxt.active_base = stu_pkg::BASE_DEC;
        take = 1'b1;
      end
    end

    // multiply-accumulate one digit, saturate when the top bits fill
    if (take) begin
      if (dval >= {1'b0, nxt.active_base} || nxt.active_base < 2) begin
        nxt.parse_phase = stu_pkg::PH_DONE;
      end else begin
        wide = stu_pkg::PROD_W'(nxt.accumulator) * stu_pkg::PROD_W'(nxt.active_base)
             + stu_pkg::PROD_W'(dval);
        if (wide[stu_pkg::PROD_W-1:stu_pkg::VALUE_WIDTH] != '0) begin
          nxt.accumulator   = '1;
          nxt.overflow_seen = 1'b1;
          nxt.negative_sign = 1'b0;
        end else begin
          nxt.accumulator = wide[stu_pkg::VALUE_WIDTH-1:0];
        end
        nxt.digit_seen  = 1'b1;
        nxt.digits_end  = stu_pkg::sat_next(pos);
        nxt.parse_phase = stu_pkg::PH_DIGITS;
      end
    end

    nxt.char_position = stu_pkg::sat_next(pos);
  end

  always_comb begin
    result_o = '0;
    if (nxt.parse_phase == stu_pkg::PH_BAD) begin
      result_o.status = stu_pkg::STATUS_INVALID;
    end else if (!nxt.digit_seen) begin
      result_o.status = stu_pkg::STATUS_NO_DIGIT;
    end else begin
      result_o.parsed_value = nxt.negative_sign ? ('0 - nxt.accumulator) : nxt.accumulator;
      result_o.end_offset   = nxt.digits_end;
      result_o.status       = nxt.overflow_seen ? stu_pkg::STATUS_OVERFLOW
                                                : stu_pkg::STATUS_OK;
    end
  end

  assign state_o = nxt;

endmodule

// ----- sv/stu_checker.sv -----
// port level checks for the string to unsigned parser, bound to the top level
// depends on stu_pkg and assert_macros.svh
`include "assert_macros.svh"

module stu_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input stu_pkg::in_word_t             in_data_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input stu_pkg::out_word_t            out_data_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [stu_pkg::BASE_W-1:0]    cfg_data_i
);

  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result word changed")
  `ASSERT_CLKD(a_fail_zero, clk_i, rst_ni, out_valid_o && (out_data_o.status == stu_pkg::STATUS_INVALID || out_data_o.status == stu_pkg::STATUS_NO_DIGIT) |-> out_data_o.parsed_value == '0 && out_data_o.end_offset == '0, "failed parse with nonzero value or offset")
  `ASSERT_CLKD(a_ovf_sat, clk_i, rst_ni, out_valid_o && out_data_o.status == stu_pkg::STATUS_OVERFLOW |-> out_data_o.parsed_value == '1, "overflow result not saturated")
  `ASSERT_CLKD(a_stall_cause, clk_i, rst_ni, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without a held result")
  `ASSERT_CLK(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind string_to_unsigned_parser_unit stu_checker u_stu_checker (.*);
